[sv/sfd_pkg.sv]
package sfd_pkg;

    localparam int MAX_FRAME = 100;
    localparam int POS_W     = $clog2(MAX_FRAME);
    // largest length byte whose frame still fits (length + 6 bytes)
    localparam int LEN_LIMIT = MAX_FRAME - 6;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CODE = 2'd0,
        CFG_END_CODE   = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FS_OK       = 2'd0,
        FS_BAD_SUM  = 2'd1,
        FS_BAD_END  = 2'd2,
        FS_TOO_LONG = 2'd3
    } frame_status_t;

    localparam logic [7:0] START_CODE_RST = 8'hF1;
    localparam logic [7:0] END_CODE_RST   = 8'h7E;

    typedef struct packed {
        logic          valid;
        logic [7:0]    rx_byte;
    } in_stage_t;

    typedef struct packed {
        logic [6:0]    frame_length;
        frame_status_t frame_status;
        logic [6:0]    byte_index;
        logic [7:0]    data_byte;
        logic          is_status;
    } result_t;

endpackage

[sv/sfd_in_reg.sv]
module sfd_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              take,
    output sfd_pkg::in_stage_t in_stage
);
    import sfd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_stage.valid   = valid_reg;
    assign in_stage.rx_byte = byte_reg;

endmodule

[sv/sfd_parse.sv]
module sfd_parse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sfd_pkg::in_stage_t            in_stage,
    output logic                          take,
    input  logic                          cfg_valid,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output sfd_pkg::result_t              res,
    output logic                          res_valid,
    input  logic                          res_ready
);
    import sfd_pkg::*;

    logic [7:0]       start_code_reg;
    logic [7:0]       end_code_reg;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] len_reg,   len_next;
    logic [7:0]       sum_reg,   sum_next;
    logic             match_reg, match_next;

    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res_next;
    logic             emit;

    logic [7:0]       b;
    logic [POS_W-1:0] len_plus4;

    assign b         = in_stage.rx_byte;
    assign len_plus4 = len_reg + POS_W'(4);
    assign take      = in_stage.valid && (!out_valid_reg || res_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg <= START_CODE_RST;
            end_code_reg   <= END_CODE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_CODE: start_code_reg <= cfg_data;
                CFG_END_CODE:   end_code_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        match_next = match_reg;
        emit       = 1'b0;
        res_next   = '0;

        if (pos_reg == '0) begin
            if (b == start_code_reg) begin
                pos_next = POS_W'(1);
            end
        end else if (pos_reg == POS_W'(1)) begin
            // a mismatch here drops back to hunting without retesting the byte
            pos_next = (b == start_code_reg) ? POS_W'(2) : '0;
        end else if (pos_reg == POS_W'(2)) begin
            sum_next           = b;
            pos_next           = POS_W'(3);
            emit               = 1'b1;
            res_next.data_byte = b;
            res_next.byte_index = 7'(pos_reg);
        end else if (pos_reg == POS_W'(3)) begin
            emit = 1'b1;
            if (b > 8'(LEN_LIMIT)) begin
                pos_next              = '0;
                res_next.is_status    = 1'b1;
                res_next.byte_index   = 7'(pos_reg);
                res_next.frame_status = FS_TOO_LONG;
                res_next.frame_length = 7'd4;
            end else begin
                len_next            = POS_W'(b);
                sum_next            = sum_reg + b;
                pos_next            = POS_W'(4);
                res_next.data_byte  = b;
                res_next.byte_index = 7'(pos_reg);
            end
        end else if (pos_reg < len_plus4) begin
            sum_next            = sum_reg + b;
            pos_next            = pos_reg + POS_W'(1);
            emit                = 1'b1;
            res_next.data_byte  = b;
            res_next.byte_index = 7'(pos_reg);
        end else if (pos_reg == len_plus4) begin
            // checksum byte: no item, verdict kept for the end byte
            match_next = (b == sum_reg);
            pos_next   = pos_reg + POS_W'(1);
        end else begin
            emit                  = 1'b1;
            pos_next              = '0;
            res_next.is_status    = 1'b1;
            res_next.byte_index   = 7'(pos_reg);
            res_next.frame_length = 7'(len_reg + POS_W'(6));
            if (b != end_code_reg) begin
                res_next.frame_status = FS_BAD_END;
            end else if (!match_reg) begin
                res_next.frame_status = FS_BAD_SUM;
            end else begin
                res_next.frame_status = FS_OK;
            end
        end

        if (pos_next == '0) begin
            len_next   = '0;
            sum_next   = '0;
            match_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                pos_reg       <= pos_next;
                len_reg       <= len_next;
                sum_reg       <= sum_next;
                match_reg     <= match_next;
                out_valid_reg <= emit;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= res_next;
        end
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < POS_W'(MAX_FRAME))
        else $error("frame position past buffer end");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= POS_W'(LEN_LIMIT))
        else $error("stored length exceeds limit");

    a_status_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && emit && res_next.is_status |=> pos_reg == '0)
        else $error("status item did not return to hunting");

    a_status_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.is_status |-> out_reg.data_byte == 8'd0)
        else $error("status item carries data");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.is_status |->
            out_reg.frame_length == 7'd0 && out_reg.byte_index >= 7'd2)
        else $error("malformed payload item");

endmodule

[sv/serial_frame_deframer_sum8_core.sv]
// Path: a byte accepted into the input register is taken by the parse stage, and its result
// item is registered in the result register, which drives m_tvalid. Throughput: one byte
// per cycle unless a held item waits on m_tready; the input register is refilled in the
// cycle the parse stage takes it, and the result register drains as the next byte is parsed.
// Bytes that end in no item (hunting, second start byte, checksum byte) keep that rate.
// Reset (aresetn low, synchronous): hunting for a start byte, both stages empty, codes F1/7E.
module serial_frame_deframer_sum8_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] data_byte, [14:8] byte_index, [16:15] frame_status, [23:17] frame_length
    output logic [sfd_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tlast,  // is_status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import sfd_pkg::*;

    in_stage_t in_stage;
    result_t   res;
    logic      take;

    assign cfg_ready = 1'b1;

    sfd_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .in_stage (in_stage)
    );

    sfd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_stage  (in_stage),
        .take      (take),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

    assign m_tdata = {res.frame_length, res.frame_status, res.byte_index, res.data_byte};
    assign m_tlast = res.is_status;

endmodule
